>>> rtl/hsvrg_pkg.sv
// Shared types, constants, microcode table and arithmetic helpers of the HSV rainbow generator.
`default_nettype none
package hsvrg_pkg;

    // Sequencer step counter width and the hue and color widths.
    localparam int STEP_W = 3;
    localparam int HUE_W  = 9;
    localparam int CH_W   = 8;

    localparam logic [HUE_W-1:0] FULL_TURN = 9'd360;

    // Reciprocal of 60 scaled by 2^16, exact for hues 0..359 after the floor.
    localparam logic [10:0] RECIP_60 = 11'd1093;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_SATURATION = 2'd0;
    localparam logic [1:0] REG_VALUE      = 2'd1;

    // Micro-operation performed in one step.
    typedef enum logic [1:0] {
        UOP_WAIT_IN,
        UOP_SECTOR,
        UOP_MUL,
        UOP_EMIT
    } t_uop;

    // Multiplier operand A.
    typedef enum logic {
        OPA_SAT,
        OPA_VAL
    } t_opa;

    // Multiplier operand B.
    typedef enum logic [1:0] {
        OPB_F,
        OPB_INV_F,
        OPB_INV_A,
        OPB_INV_S
    } t_opb;

    // Destination of the scaled product.
    typedef enum logic [1:0] {
        DST_A,
        DST_Q,
        DST_T,
        DST_P
    } t_dst;

    // Condition that holds a step in place (jump to its target).
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_OUT_BUSY
    } t_cond;

    // One control word of the microprogram.
    typedef struct packed {
        t_uop              uop;
        t_opa              opa;
        t_opb              opb;
        t_dst              dst;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // Status flags that the datapath hands to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } t_seq_stat;

    // Microprogram: wait for a tick, split the hue, five scaled products, emit.
    function automatic t_ctrl f_ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{uop: UOP_MUL, opa: OPA_SAT, opb: OPB_F, dst: DST_A,
              cond: COND_NEVER, target: step};
        case (step)
            3'd0: begin
                w.uop  = UOP_WAIT_IN;
                w.cond = COND_NO_INPUT;
            end
            3'd1: begin
                w.uop = UOP_SECTOR;
            end
            3'd2: begin
                // a = s*f/255
                w.opa = OPA_SAT;
                w.opb = OPB_F;
                w.dst = DST_A;
            end
            3'd3: begin
                // q = v*(255-a)/255
                w.opa = OPA_VAL;
                w.opb = OPB_INV_A;
                w.dst = DST_Q;
            end
            3'd4: begin
                // a = s*(255-f)/255
                w.opa = OPA_SAT;
                w.opb = OPB_INV_F;
                w.dst = DST_A;
            end
            3'd5: begin
                // t = v*(255-a)/255
                w.opa = OPA_VAL;
                w.opb = OPB_INV_A;
                w.dst = DST_T;
            end
            3'd6: begin
                // p = v*(255-s)/255
                w.opa = OPA_VAL;
                w.opb = OPB_INV_S;
                w.dst = DST_P;
            end
            3'd7: begin
                w.uop  = UOP_EMIT;
                w.cond = COND_OUT_BUSY;
            end
            default: begin
                w.uop = UOP_WAIT_IN;
            end
        endcase
        return w;
    endfunction

    // Floor division by 255 of a product of two 8-bit values.
    function automatic logic [CH_W-1:0] f_div255(input logic [2*CH_W-1:0] x);
        logic [2*CH_W:0] sum;
        sum = {1'b0, x} + {9'd0, x[2*CH_W-1:CH_W]} + 17'd1;
        return sum[2*CH_W-1:CH_W];
    endfunction

endpackage
`default_nettype wire

>>> rtl/hsv_rainbow_color_generator.sv
// An accepted tick passes the sector step, five multiply steps and the emit step to its color
// in the output register, if not stalled. The eight-step microprogram takes a new tick only
// after emit and shares one 8x8 multiplier with a divide-by-255 for the p, q and t terms.
// The emit step waits while an earlier color is still held on a stalled output.
// Reset (synchronous, active low) sets saturation and value to 255, hue to 0,
// the sequencer to its first step and clears the output valid.
`default_nettype none
module hsv_rainbow_color_generator (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_hue_step,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue
);

    hsvrg_pkg::t_ctrl     w_ctrl;
    hsvrg_pkg::t_seq_stat w_stat;

    logic [7:0] r_sat;
    logic [7:0] r_val;
    logic [8:0] r_hue;
    logic [7:0] r_step;
    logic [2:0] r_sector;
    logic [7:0] r_f;
    logic [7:0] r_a;
    logic [7:0] r_p;
    logic [7:0] r_q;
    logic [7:0] r_t;
    logic       r_out_valid;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;

    logic        w_in_accept;
    logic        w_out_accept;
    logic        w_emit;
    logic [19:0] w_hue_prod;
    logic [2:0]  w_sector;
    logic [8:0]  w_sector_base;
    logic [5:0]  w_rem;
    logic [9:0]  w_rem17;
    logic [7:0]  w_opa;
    logic [7:0]  w_opb;
    logic [15:0] w_prod;
    logic [7:0]  w_scaled;
    logic [9:0]  w_hue_sum;
    logic [8:0]  w_hue_next;
    logic [7:0]  w_red;
    logic [7:0]  w_green;
    logic [7:0]  w_blue;

    // Sequencer.
    assign w_stat.in_valid = i_in_valid;
    assign w_stat.out_busy = r_out_valid && i_out_stall;

    hsvrg_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // Handshakes.
    assign o_in_stall   = (w_ctrl.uop != hsvrg_pkg::UOP_WAIT_IN);
    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_out_accept = r_out_valid && !i_out_stall;
    assign w_emit       = (w_ctrl.uop == hsvrg_pkg::UOP_EMIT) && !w_stat.out_busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 8'd255;
            r_val <= 8'd255;
        end else if (i_cfg_we) begin
            if (i_cfg_index == hsvrg_pkg::REG_SATURATION) begin
                r_sat <= i_cfg_data;
            end
            if (i_cfg_index == hsvrg_pkg::REG_VALUE) begin
                r_val <= i_cfg_data;
            end
        end
    end

    // Sector and fraction: sector = h/60, f = (h mod 60)*255/60 = (h mod 60)*17/4.
    assign w_hue_prod    = {11'd0, r_hue} * {9'd0, hsvrg_pkg::RECIP_60};
    assign w_sector      = w_hue_prod[18:16];
    assign w_sector_base = {w_sector, 6'd0} - {4'd0, w_sector, 2'd0};
    assign w_rem         = 6'(r_hue - w_sector_base);
    assign w_rem17       = {w_rem, 4'd0} + {4'd0, w_rem};

    // Shared multiplier with divide-by-255.
    always_comb begin
        case (w_ctrl.opa)
            hsvrg_pkg::OPA_VAL: w_opa = r_val;
            default:            w_opa = r_sat;
        endcase
        case (w_ctrl.opb)
            hsvrg_pkg::OPB_INV_F: w_opb = ~r_f;
            hsvrg_pkg::OPB_INV_A: w_opb = ~r_a;
            hsvrg_pkg::OPB_INV_S: w_opb = ~r_sat;
            default:              w_opb = r_f;
        endcase
    end

    assign w_prod   = {8'd0, w_opa} * {8'd0, w_opb};
    assign w_scaled = hsvrg_pkg::f_div255(w_prod);

    // Hue advance with a single wrap.
    assign w_hue_sum  = {1'b0, r_hue} + {2'd0, r_step};
    assign w_hue_next = (w_hue_sum >= {1'b0, hsvrg_pkg::FULL_TURN})
                      ? 9'(w_hue_sum - {1'b0, hsvrg_pkg::FULL_TURN})
                      : w_hue_sum[8:0];

    // Channel selection by sector.
    always_comb begin
        case (r_sector)
            3'd0:    begin w_red = r_val; w_green = r_t;   w_blue = r_p;   end
            3'd1:    begin w_red = r_q;   w_green = r_val; w_blue = r_p;   end
            3'd2:    begin w_red = r_p;   w_green = r_val; w_blue = r_t;   end
            3'd3:    begin w_red = r_p;   w_green = r_q;   w_blue = r_val; end
            3'd4:    begin w_red = r_t;   w_green = r_p;   w_blue = r_val; end
            default: begin w_red = r_val; w_green = r_p;   w_blue = r_q;   end
        endcase
    end

    // Hue state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue <= '0;
        end else if (w_emit) begin
            r_hue <= w_hue_next;
        end
    end

    // Datapath working registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_step <= i_hue_step;
        end
        if (w_ctrl.uop == hsvrg_pkg::UOP_SECTOR) begin
            r_sector <= w_sector;
            r_f      <= w_rem17[9:2];
        end
        if (w_ctrl.uop == hsvrg_pkg::UOP_MUL) begin
            case (w_ctrl.dst)
                hsvrg_pkg::DST_Q: r_q <= w_scaled;
                hsvrg_pkg::DST_T: r_t <= w_scaled;
                hsvrg_pkg::DST_P: r_p <= w_scaled;
                default:          r_a <= w_scaled;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (w_out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_red   <= w_red;
            r_green <= w_green;
            r_blue  <= w_blue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

`ifndef SYNTHESIS
    // The hue stays within one turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hue < hsvrg_pkg::FULL_TURN)
        else $error("hue out of range");

    // A tick starts the program; no second tick is taken right after.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("second item accepted during conversion");

    // A new color appears only from the emit step.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctrl.uop == hsvrg_pkg::UOP_EMIT))
        else $error("output valid without emit step");

    // The hue moves only when a color is emitted.
    a_hue_moves_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_emit |=> $stable(r_hue))
        else $error("hue changed outside emit");
`endif

endmodule
`default_nettype wire

>>> rtl/hsvrg_sequencer.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none
module hsvrg_sequencer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hsvrg_pkg::t_seq_stat i_stat,
    output hsvrg_pkg::t_ctrl        o_ctrl
);

    logic [hsvrg_pkg::STEP_W-1:0] r_step;
    logic [hsvrg_pkg::STEP_W-1:0] n_step;
    hsvrg_pkg::t_ctrl             w_ctrl;
    logic                         w_hold;

    // Control word of the current step.
    assign w_ctrl = hsvrg_pkg::f_ucode(r_step);
    assign o_ctrl = w_ctrl;

    // Jump condition and next step.
    always_comb begin
        case (w_ctrl.cond)
            hsvrg_pkg::COND_NO_INPUT: w_hold = !i_stat.in_valid;
            hsvrg_pkg::COND_OUT_BUSY: w_hold = i_stat.out_busy;
            default:                  w_hold = 1'b0;
        endcase
        n_step = w_hold ? w_ctrl.target : r_step + 3'd1;
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire
